[src/clook_request_scheduler_defines.svh]
// Assertion macros for the sorted request scheduler.
// Used by clook_request_scheduler.sv; needs clk_i and rst_ni in scope.
`ifndef CLOOK_REQUEST_SCHEDULER_DEFINES_SVH
`define CLOOK_REQUEST_SCHEDULER_DEFINES_SVH

`define CLRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CLRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`define CLRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[src/clrs_pkg.sv]
// Shared types for the sorted request scheduler.
// No dependencies; used by clrs_cell and clook_request_scheduler.
package clrs_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_REMOVE   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOTAG = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  typedef struct packed {
    logic  eval;
    logic  ins;
    logic  del;
    func_e op;
  } ctrl_t;

endpackage

[src/clook_request_scheduler.sv]
// Top level of the sorted request scheduler: command registers, sequencer
// and a row of clrs_cell slots. Depends on clrs_pkg and the defines header.
// Each item passes through states S_EVAL and S_APPLY: on accept the command
// is latched, in S_EVAL one compare flag per slot is stored, and in S_APPLY
// the row shifts and the result is loaded. busy is high in both states, and
// a new item can be started while the previous result is shown. valid_o is
// high for exactly one cycle with each result, which cannot be stalled, so
// capture it in that cycle.
`include "clook_request_scheduler_defines.svh"

module clook_request_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             func_i,
  input  logic [SECTOR_BITS-1:0] req_sector_i,
  input  logic [TAG_BITS-1:0]    req_tag_i,
  input  logic                   req_is_write_i,
  output logic                   valid_o,
  output logic [1:0]             status_o,
  output logic [SECTOR_BITS-1:0] out_sector_o,
  output logic [TAG_BITS-1:0]    out_tag_o,
  output logic                   out_is_write_o
);
  import clrs_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  state_e                 state_q, state_d;
  func_e                  func_q;
  logic [SECTOR_BITS-1:0] cmd_sector_q;
  logic [TAG_BITS-1:0]    cmd_tag_q;
  logic                   cmd_wr_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SECTOR_BITS-1:0] last_q, last_d;

  logic                   valid_q;
  status_e                status_q, status_d;
  logic [SECTOR_BITS-1:0] osec_q, osec_d;
  logic [TAG_BITS-1:0]    otag_q, otag_d;
  logic                   owr_q, owr_d;

  logic [SECTOR_BITS-1:0] sec [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] wr, hit, first, pick;
  logic [QUEUE_DEPTH:0]   pre;
  logic                   any_hit, full, empty, accept;
  logic [SECTOR_BITS-1:0] sel_sector;
  logic [TAG_BITS-1:0]    sel_tag;
  logic                   sel_wr;
  ctrl_t                  ctrl;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign any_hit = pre[QUEUE_DEPTH];
  assign full    = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty   = (cnt_q == '0);
  assign pre[0]  = 1'b0;

  assign ctrl.op   = func_q;
  assign ctrl.eval = (state_q == S_EVAL);
  assign ctrl.ins  = (state_q == S_APPLY) && (func_q == FUNC_ADD) && !full;
  assign ctrl.del  = (state_q == S_APPLY) &&
                     (((func_q == FUNC_DISPATCH) && !empty) ||
                      ((func_q == FUNC_REMOVE) && any_hit));

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [SECTOR_BITS-1:0] l_sec, r_sec;
    logic [TAG_BITS-1:0]    l_tag, r_tag;
    logic                   l_wr, r_wr, l_hit;

    if (g == 0) begin : g_head
      assign l_sec = cmd_sector_q;
      assign l_tag = cmd_tag_q;
      assign l_wr  = cmd_wr_q;
      assign l_hit = 1'b0;
    end else begin : g_body
      assign l_sec = sec[g-1];
      assign l_tag = tag[g-1];
      assign l_wr  = wr[g-1];
      assign l_hit = hit[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign r_sec = sec[g];
      assign r_tag = tag[g];
      assign r_wr  = wr[g];
    end else begin : g_inner
      assign r_sec = sec[g+1];
      assign r_tag = tag[g+1];
      assign r_wr  = wr[g+1];
    end

    assign pick[g] = any_hit ? first[g] : (g == 0);

    clrs_cell #(
      .SectorBits(SECTOR_BITS),
      .TagBits   (TAG_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .occ_i         (cnt_q > CntW'(g)),
      .cmd_sector_i  (cmd_sector_q),
      .cmd_tag_i     (cmd_tag_q),
      .cmd_wr_i      (cmd_wr_q),
      .floor_sector_i(last_q),
      .wrap_i        (!any_hit),
      .left_sector_i (l_sec),
      .left_tag_i    (l_tag),
      .left_wr_i     (l_wr),
      .left_hit_i    (l_hit),
      .right_sector_i(r_sec),
      .right_tag_i   (r_tag),
      .right_wr_i    (r_wr),
      .pre_i         (pre[g]),
      .sector_o      (sec[g]),
      .tag_o         (tag[g]),
      .wr_o          (wr[g]),
      .hit_o         (hit[g]),
      .pre_o         (pre[g+1]),
      .first_o       (first[g])
    );
  end

  always_comb begin
    sel_sector = '0;
    sel_tag    = '0;
    sel_wr     = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_sector = sel_sector | ({SECTOR_BITS{pick[i]}} & sec[i]);
      sel_tag    = sel_tag | ({TAG_BITS{pick[i]}} & tag[i]);
      sel_wr     = sel_wr | (pick[i] & wr[i]);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    status_d = status_q;
    osec_d   = osec_q;
    otag_d   = otag_q;
    owr_d    = owr_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d  = S_IDLE;
        status_d = ST_OK;
        osec_d   = '0;
        otag_d   = '0;
        owr_d    = 1'b0;
        case (func_q)
          FUNC_ADD: begin
            if (full) status_d = ST_FULL;
            else cnt_d = cnt_q + 1'b1;
          end
          FUNC_DISPATCH: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              cnt_d  = cnt_q - 1'b1;
              last_d = sel_sector;
              osec_d = sel_sector;
              otag_d = sel_tag;
              owr_d  = sel_wr;
            end
          end
          FUNC_REMOVE: begin
            if (any_hit) cnt_d = cnt_q - 1'b1;
            else status_d = ST_NOTAG;
          end
          default: status_d = ST_OK;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      valid_q <= (state_q == S_APPLY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q       <= func_e'(func_i);
      cmd_sector_q <= req_sector_i;
      cmd_tag_q    <= req_tag_i;
      cmd_wr_q     <= req_is_write_i;
    end
    status_q <= status_d;
    osec_q   <= osec_d;
    otag_q   <= otag_d;
    owr_q    <= owr_d;
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign out_sector_o   = osec_q;
  assign out_tag_o      = otag_q;
  assign out_is_write_o = owr_q;

  `CLRS_ASSERT(a_cnt_bound, cnt_q <= CntW'(QUEUE_DEPTH), "entry count above depth")
  `CLRS_ASSERT_IMP(a_valid_src, valid_q, $past(state_q == S_APPLY), "result without apply")
  `CLRS_ASSERT_NXT(a_accept_eval, accept, state_q == S_EVAL, "accepted item not evaluated")
  `CLRS_ASSERT_IMP(a_pick_onehot, state_q == S_APPLY, $onehot0(pick), "more than one slot picked")
  `CLRS_ASSERT_NXT(a_ins_grow, ctrl.ins, cnt_q == $past(cnt_q) + 1'b1, "insert did not grow queue")

endmodule

[src/clrs_cell.sv]
// One queue slot of the sorted request scheduler: holds an entry and a
// compare flag, shifts toward its neighbors. Depends on clrs_pkg.
module clrs_cell #(
  parameter int SectorBits = 48,
  parameter int TagBits    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clrs_pkg::ctrl_t       ctrl_i,
  input  logic                  occ_i,
  input  logic [SectorBits-1:0] cmd_sector_i,
  input  logic [TagBits-1:0]    cmd_tag_i,
  input  logic                  cmd_wr_i,
  input  logic [SectorBits-1:0] floor_sector_i,
  input  logic                  wrap_i,
  input  logic [SectorBits-1:0] left_sector_i,
  input  logic [TagBits-1:0]    left_tag_i,
  input  logic                  left_wr_i,
  input  logic                  left_hit_i,
  input  logic [SectorBits-1:0] right_sector_i,
  input  logic [TagBits-1:0]    right_tag_i,
  input  logic                  right_wr_i,
  input  logic                  pre_i,
  output logic [SectorBits-1:0] sector_o,
  output logic [TagBits-1:0]    tag_o,
  output logic                  wr_o,
  output logic                  hit_o,
  output logic                  pre_o,
  output logic                  first_o
);
  import clrs_pkg::*;

  logic [SectorBits-1:0] sector_q, sector_d;
  logic [TagBits-1:0]    tag_q, tag_d;
  logic                  wr_q, wr_d;
  logic                  hit_q, hit_d;

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.eval) begin
      case (ctrl_i.op)
        FUNC_ADD:      hit_d = !occ_i || (sector_q > cmd_sector_i);
        FUNC_DISPATCH: hit_d = occ_i && (sector_q >= floor_sector_i);
        FUNC_REMOVE:   hit_d = occ_i && (tag_q == cmd_tag_i);
        default:       hit_d = 1'b0;
      endcase
    end
  end

  assign pre_o   = pre_i | hit_q;
  assign first_o = hit_q & ~pre_i;

  always_comb begin
    sector_d = sector_q;
    tag_d    = tag_q;
    wr_d     = wr_q;
    if (ctrl_i.ins) begin
      if (left_hit_i) begin
        sector_d = left_sector_i;
        tag_d    = left_tag_i;
        wr_d     = left_wr_i;
      end else if (hit_q) begin
        sector_d = cmd_sector_i;
        tag_d    = cmd_tag_i;
        wr_d     = cmd_wr_i;
      end
    end else if (ctrl_i.del && (wrap_i || pre_o)) begin
      sector_d = right_sector_i;
      tag_d    = right_tag_i;
      wr_d     = right_wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    tag_q    <= tag_d;
    wr_q     <= wr_d;
  end

  assign sector_o = sector_q;
  assign tag_o    = tag_q;
  assign wr_o     = wr_q;
  assign hit_o    = hit_q;

endmodule
